[src/xxh64_stream_hash_unit_defines.svh]
// Assertion macros for the XXH64 stream hash unit.
// Taken in by xxh_ctrl, which checks its own control logic.
`ifndef XXH64_STREAM_HASH_UNIT_DEFINES_SVH
`define XXH64_STREAM_HASH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define XXH_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("xxh64 check failed");
`define XXH_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("xxh64 reset check failed");
`else
`define XXH_ASSERT(name, clk, rstn, prop)
`define XXH_ASSERT_RST(name, clk, prop)
`endif
`endif

[src/xxh_pkg.sv]
// Shared types, constants and the microcode table of the XXH64 stream hash unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package xxh_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  localparam logic [63:0] LANE0_INIT = P1 + P2;
  localparam logic [63:0] LANE1_INIT = P2;
  localparam logic [63:0] LANE2_INIT = 64'd0;
  localparam logic [63:0] LANE3_INIT = 64'd0 - P1;

  localparam logic [3:0] FULL_COUNT = 4'd8;

  localparam logic [2:0] K_ZERO = 3'd0;
  localparam logic [2:0] K_P1   = 3'd1;
  localparam logic [2:0] K_P2   = 3'd2;
  localparam logic [2:0] K_P3   = 3'd3;
  localparam logic [2:0] K_P4   = 3'd4;
  localparam logic [2:0] K_P5   = 3'd5;

  localparam logic [2:0] R_31 = 3'd0;
  localparam logic [2:0] R_27 = 3'd1;
  localparam logic [2:0] R_23 = 3'd2;
  localparam logic [2:0] R_11 = 3'd3;

  localparam logic [2:0] S_33 = 3'd0;
  localparam logic [2:0] S_29 = 3'd1;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_DECIDE = 4'd1;
  localparam logic [3:0] PH_ABSORB = 4'd2;
  localparam logic [3:0] PH_CONV   = 4'd3;
  localparam logic [3:0] PH_MERGE  = 4'd4;
  localparam logic [3:0] PH_HLEN   = 4'd5;
  localparam logic [3:0] PH_TAILW  = 4'd6;
  localparam logic [3:0] PH_TAIL4  = 4'd7;
  localparam logic [3:0] PH_TAILB  = 4'd8;
  localparam logic [3:0] PH_AVAL   = 4'd9;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_BUF_WR,
    OP_LD_WORD,
    OP_LD_LANE,
    OP_LD_PART4,
    OP_LD_BYTE,
    OP_LD_H,
    OP_MUL_LO,
    OP_MUL_HI_A,
    OP_MUL_HI_B,
    OP_LANE_ADD_ROT,
    OP_ROT,
    OP_XSHR,
    OP_XOR_H,
    OP_LANE_ST,
    OP_H_CONV,
    OP_H_LEN,
    OP_H_ADDK,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] arg;
    logic [1:0] idx;
    logic [2:0] byte_idx;
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic       last;
    logic [1:0] pos;
    logic       seen;
    logic [3:0] pcount;
  } status_t;

  typedef struct packed {
    op_e        op;
    logic [2:0] arg;
    logic       done;
  } uop_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] kconst(input logic [2:0] sel);
    logic [63:0] k;
    unique case (sel)
      K_P1:    k = P1;
      K_P2:    k = P2;
      K_P3:    k = P3;
      K_P4:    k = P4;
      K_P5:    k = P5;
      default: k = 64'd0;
    endcase
    return k;
  endfunction

  function automatic uop_t mul_u(input logic [3:0] j, input logic [2:0] k);
    uop_t u;
    u.arg  = k;
    u.done = 1'b0;
    unique case (j)
      4'd0:    u.op = OP_MUL_LO;
      4'd1:    u.op = OP_MUL_HI_A;
      default: u.op = OP_MUL_HI_B;
    endcase
    return u;
  endfunction

  function automatic uop_t mk(input op_e op, input logic [2:0] arg, input logic done);
    uop_t u;
    u.op   = op;
    u.arg  = arg;
    u.done = done;
    return u;
  endfunction

  function automatic uop_t ucode(input logic [3:0] phase, input logic [3:0] step);
    uop_t u;
    u = mk(OP_NONE, K_ZERO, 1'b1);
    unique case (phase)
      PH_ABSORB: begin
        unique case (step)
          4'd0:                u = mk(OP_LD_WORD, K_ZERO, 1'b0);
          4'd1, 4'd2, 4'd3:    u = mul_u(step - 4'd1, K_P2);
          4'd4:                u = mk(OP_LANE_ADD_ROT, K_ZERO, 1'b0);
          4'd5, 4'd6, 4'd7:    u = mul_u(step - 4'd5, K_P1);
          default:             u = mk(OP_LANE_ST, K_ZERO, 1'b1);
        endcase
      end
      PH_MERGE: begin
        unique case (step)
          4'd0:                u = mk(OP_LD_LANE, K_ZERO, 1'b0);
          4'd1, 4'd2, 4'd3:    u = mul_u(step - 4'd1, K_P2);
          4'd4:                u = mk(OP_ROT, R_31, 1'b0);
          4'd5, 4'd6, 4'd7:    u = mul_u(step - 4'd5, K_P1);
          4'd8:                u = mk(OP_XOR_H, K_ZERO, 1'b0);
          4'd9, 4'd10, 4'd11:  u = mul_u(step - 4'd9, K_P1);
          default:             u = mk(OP_H_ADDK, K_P4, 1'b1);
        endcase
      end
      PH_TAILW: begin
        unique case (step)
          4'd0:                u = mk(OP_LD_WORD, K_ZERO, 1'b0);
          4'd1, 4'd2, 4'd3:    u = mul_u(step - 4'd1, K_P2);
          4'd4:                u = mk(OP_ROT, R_31, 1'b0);
          4'd5, 4'd6, 4'd7:    u = mul_u(step - 4'd5, K_P1);
          4'd8:                u = mk(OP_XOR_H, K_ZERO, 1'b0);
          4'd9:                u = mk(OP_ROT, R_27, 1'b0);
          4'd10, 4'd11, 4'd12: u = mul_u(step - 4'd10, K_P1);
          default:             u = mk(OP_H_ADDK, K_P4, 1'b1);
        endcase
      end
      PH_TAIL4: begin
        unique case (step)
          4'd0:                u = mk(OP_LD_PART4, K_ZERO, 1'b0);
          4'd1, 4'd2, 4'd3:    u = mul_u(step - 4'd1, K_P1);
          4'd4:                u = mk(OP_XOR_H, K_ZERO, 1'b0);
          4'd5:                u = mk(OP_ROT, R_23, 1'b0);
          4'd6, 4'd7, 4'd8:    u = mul_u(step - 4'd6, K_P2);
          default:             u = mk(OP_H_ADDK, K_P3, 1'b1);
        endcase
      end
      PH_TAILB: begin
        unique case (step)
          4'd0:                u = mk(OP_LD_BYTE, K_ZERO, 1'b0);
          4'd1, 4'd2, 4'd3:    u = mul_u(step - 4'd1, K_P5);
          4'd4:                u = mk(OP_XOR_H, K_ZERO, 1'b0);
          4'd5:                u = mk(OP_ROT, R_11, 1'b0);
          4'd6, 4'd7, 4'd8:    u = mul_u(step - 4'd6, K_P1);
          default:             u = mk(OP_H_ADDK, K_ZERO, 1'b1);
        endcase
      end
      PH_AVAL: begin
        unique case (step)
          4'd0:                u = mk(OP_LD_H, K_ZERO, 1'b0);
          4'd1:                u = mk(OP_XSHR, S_33, 1'b0);
          4'd2, 4'd3, 4'd4:    u = mul_u(step - 4'd2, K_P2);
          4'd5:                u = mk(OP_XSHR, S_29, 1'b0);
          4'd6, 4'd7, 4'd8:    u = mul_u(step - 4'd6, K_P3);
          default:             u = mk(OP_OUT, K_ZERO, 1'b1);
        endcase
      end
      PH_CONV:   u = mk(OP_H_CONV, K_ZERO, 1'b1);
      PH_HLEN:   u = mk(OP_H_LEN, K_ZERO, 1'b1);
      default:   u = mk(OP_NONE, K_ZERO, 1'b1);
    endcase
    return u;
  endfunction

endpackage

[src/xxh64_stream_hash_unit.sv]
// Top level of the XXH64 (seed zero) stream hash unit.
// Joins the controller xxh_ctrl and the datapath xxh_dp; uses xxh_pkg.
//
//   channel | signals                                   | direction
//   input   | in_valid_i, in_stall_o, data_word_i,      | into the block
//           | byte_count_i, last_word_i                 |
//   output  | out_valid_o, out_stall_i, hash_value_o    | out of the block
//
// A full word that does not end a stripe is buffered; one that ends a stripe runs four
// lane rounds through the single shared 32 by 32 multiplier. The last word adds the lane
// merge (when a stripe was seen), the length, a round per buffered word, one for four
// tail bytes, one per single byte and the final mix.
// Reset is asynchronous and active low and leaves the block ready for a new message.
// A result waits in an output register; a new message can be taken meanwhile, and
// its result is not written until that register is taken.
module xxh64_stream_hash_unit import xxh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  cmd_t    cmd;
  status_t status;

  xxh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xxh_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .status_o     (status),
    .hash_value_o (hash_value_o)
  );

endmodule

[src/xxh_dp.sv]
// Datapath of the XXH64 stream hash unit: lanes, stripe buffer, length, work registers
// and one shared 32 by 32 multiplier. Executes commands from xxh_ctrl; uses xxh_pkg.
module xxh_dp import xxh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output status_t     status_o,
  output logic [63:0] hash_value_o
);

  logic [63:0] lane_q [4];
  logic [63:0] lane_d [4];
  logic [63:0] buf_q [3];
  logic [63:0] buf_d [3];
  logic [1:0]  pos_q, pos_d;
  logic [63:0] len_q, len_d;
  logic        seen_q, seen_d;
  logic [63:0] w_q, w_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        last_q, last_d;
  logic [63:0] x_q, x_d;
  logic [63:0] h_q, h_d;
  logic [63:0] p_q, p_d;
  logic [63:0] out_q, out_d;
  logic [63:0] k;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [63:0] word_sel;
  logic [63:0] lane_sel;
  logic [3:0]  cnt_in;

  assign k        = kconst(cmd_i.arg);
  assign prod     = {32'd0, ma} * {32'd0, mb};
  assign lane_sel = lane_q[cmd_i.idx];
  assign cnt_in   = (byte_count_i > FULL_COUNT) ? FULL_COUNT : byte_count_i;

  always_comb begin
    unique case (cmd_i.idx)
      2'd0:    word_sel = buf_q[0];
      2'd1:    word_sel = buf_q[1];
      2'd2:    word_sel = buf_q[2];
      default: word_sel = w_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_MUL_HI_A: begin
        ma = x_q[63:32];
        mb = k[31:0];
      end
      OP_MUL_HI_B: begin
        ma = x_q[31:0];
        mb = k[63:32];
      end
      default: begin
        ma = x_q[31:0];
        mb = k[31:0];
      end
    endcase
  end

  always_comb begin
    lane_d = lane_q;
    buf_d  = buf_q;
    pos_d  = pos_q;
    len_d  = len_q;
    seen_d = seen_q;
    w_d    = w_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    x_d    = x_q;
    h_d    = h_q;
    p_d    = p_q;
    out_d  = out_q;
    case (cmd_i.op)
      OP_CAPTURE: begin
        w_d    = data_word_i;
        cnt_d  = cnt_in;
        last_d = last_word_i;
        len_d  = len_q + {60'd0, cnt_in};
      end
      OP_BUF_WR: begin
        case (pos_q)
          2'd0:    buf_d[0] = w_q;
          2'd1:    buf_d[1] = w_q;
          default: buf_d[2] = w_q;
        endcase
        pos_d = pos_q + 2'd1;
      end
      OP_LD_WORD:  x_d = word_sel;
      OP_LD_LANE:  x_d = lane_sel;
      OP_LD_PART4: x_d = {32'd0, w_q[31:0]};
      OP_LD_BYTE:  x_d = {56'd0, w_q[{cmd_i.byte_idx, 3'b000} +: 8]};
      OP_LD_H:     x_d = h_q;
      OP_MUL_LO:   p_d = prod;
      OP_MUL_HI_A: p_d = p_q + {prod[31:0], 32'd0};
      OP_MUL_HI_B: x_d = p_q + {prod[31:0], 32'd0};
      OP_LANE_ADD_ROT: x_d = rotl64(lane_sel + x_q, 31);
      OP_ROT: begin
        case (cmd_i.arg)
          R_27:    x_d = rotl64(x_q, 27);
          R_23:    x_d = rotl64(x_q, 23);
          R_11:    x_d = rotl64(x_q, 11);
          default: x_d = rotl64(x_q, 31);
        endcase
      end
      OP_XSHR: x_d = (cmd_i.arg == S_29) ? (x_q ^ (x_q >> 29)) : (x_q ^ (x_q >> 33));
      OP_XOR_H: x_d = x_q ^ h_q;
      OP_LANE_ST: begin
        lane_d[cmd_i.idx] = x_q;
        if (cmd_i.idx == 2'd3) begin
          pos_d  = 2'd0;
          seen_d = 1'b1;
        end
      end
      OP_H_CONV: begin
        if (seen_q) begin
          h_d = rotl64(lane_q[0], 1) + rotl64(lane_q[1], 7) +
                rotl64(lane_q[2], 12) + rotl64(lane_q[3], 18);
        end else begin
          h_d = P5;
        end
      end
      OP_H_LEN:  h_d = h_q + len_q;
      OP_H_ADDK: h_d = x_q + k;
      OP_OUT: begin
        out_d     = x_q ^ (x_q >> 32);
        lane_d[0] = LANE0_INIT;
        lane_d[1] = LANE1_INIT;
        lane_d[2] = LANE2_INIT;
        lane_d[3] = LANE3_INIT;
        pos_d     = 2'd0;
        len_d     = 64'd0;
        seen_d    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q[0] <= LANE0_INIT;
      lane_q[1] <= LANE1_INIT;
      lane_q[2] <= LANE2_INIT;
      lane_q[3] <= LANE3_INIT;
      pos_q     <= 2'd0;
      len_q     <= 64'd0;
      seen_q    <= 1'b0;
    end else begin
      lane_q <= lane_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    w_q    <= w_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
    x_q    <= x_d;
    h_q    <= h_d;
    p_q    <= p_d;
    out_q  <= out_d;
  end

  assign status_o.full   = (cnt_q == FULL_COUNT);
  assign status_o.last   = last_q;
  assign status_o.pos    = pos_q;
  assign status_o.seen   = seen_q;
  assign status_o.pcount = (cnt_q == FULL_COUNT) ? 4'd0 : cnt_q;
  assign hash_value_o    = out_q;

endmodule

[src/xxh_ctrl.sv]
// Controller of the XXH64 stream hash unit: phase state machine, microcode stepping
// and the output valid flag. Uses xxh_pkg and the assertion macros.
`include "xxh64_stream_hash_unit_defines.svh"
module xxh_ctrl import xxh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  logic [3:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [1:0] idx_q, idx_d;
  logic [2:0] byte_q, byte_d;
  logic       out_valid_q, out_valid_d;
  logic       advance;
  uop_t       u;

  assign u       = ucode(state_q, step_q);
  assign advance = !((u.op == OP_OUT) && out_valid_q && out_stall_i);

  always_comb begin
    state_d          = state_q;
    step_d           = step_q;
    idx_d            = idx_q;
    byte_d           = byte_q;
    cmd_o.op         = OP_NONE;
    cmd_o.arg        = u.arg;
    cmd_o.idx        = idx_q;
    cmd_o.byte_idx   = byte_q;
    unique case (state_q)
      PH_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = PH_DECIDE;
        end
      end
      PH_DECIDE: begin
        step_d = 4'd0;
        idx_d  = 2'd0;
        if (status_i.full && (status_i.pos == 2'd3)) begin
          state_d = PH_ABSORB;
        end else if (status_i.full) begin
          cmd_o.op = OP_BUF_WR;
          state_d  = status_i.last ? PH_CONV : PH_IDLE;
        end else begin
          state_d = PH_CONV;
        end
      end
      default: begin
        if (advance) begin
          cmd_o.op = u.op;
          if (!u.done) begin
            step_d = step_q + 4'd1;
          end else begin
            step_d = 4'd0;
            unique case (state_q)
              PH_ABSORB: begin
                if (idx_q == 2'd3) begin
                  state_d = status_i.last ? PH_CONV : PH_IDLE;
                end else begin
                  idx_d = idx_q + 2'd1;
                end
              end
              PH_CONV: begin
                idx_d   = 2'd0;
                state_d = status_i.seen ? PH_MERGE : PH_HLEN;
              end
              PH_MERGE: begin
                if (idx_q == 2'd3) begin
                  state_d = PH_HLEN;
                end else begin
                  idx_d = idx_q + 2'd1;
                end
              end
              PH_HLEN, PH_TAILW: begin
                if ((state_q == PH_HLEN) && (status_i.pos != 2'd0)) begin
                  idx_d   = 2'd0;
                  state_d = PH_TAILW;
                end else if ((state_q == PH_TAILW) &&
                             ({1'b0, idx_q} + 3'd1 < {1'b0, status_i.pos})) begin
                  idx_d = idx_q + 2'd1;
                end else if (status_i.pcount >= 4'd4) begin
                  state_d = PH_TAIL4;
                end else if (status_i.pcount != 4'd0) begin
                  byte_d  = 3'd0;
                  state_d = PH_TAILB;
                end else begin
                  state_d = PH_AVAL;
                end
              end
              PH_TAIL4: begin
                byte_d  = 3'd4;
                state_d = (status_i.pcount > 4'd4) ? PH_TAILB : PH_AVAL;
              end
              PH_TAILB: begin
                if ({1'b0, byte_q} + 4'd1 < status_i.pcount) begin
                  byte_d = byte_q + 3'd1;
                end else begin
                  state_d = PH_AVAL;
                end
              end
              default: state_d = PH_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PH_IDLE;
      step_q      <= 4'd0;
      idx_q       <= 2'd0;
      byte_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      byte_q      <= byte_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != PH_IDLE);
  assign out_valid_o = out_valid_q;

  `XXH_ASSERT(a_out_slot_free, clk_i, rst_ni, (cmd_o.op == OP_OUT) |-> (!out_valid_q || !out_stall_i))
  `XXH_ASSERT(a_tail_word_in_buffer, clk_i, rst_ni, (state_q == PH_TAILW) |-> ({1'b0, idx_q} < {1'b0, status_i.pos}))
  `XXH_ASSERT(a_tail_byte_in_count, clk_i, rst_ni, (state_q == PH_TAILB) |-> ({1'b0, byte_q} < status_i.pcount))
  `XXH_ASSERT(a_result_after_finish, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == PH_AVAL))

endmodule
